@@ src/keyed_cooldown_table_core_macros.svh @@
// Assertion macros used by the cooldown table core.
`ifndef KEYED_COOLDOWN_TABLE_CORE_MACROS_SVH
`define KEYED_COOLDOWN_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define KCT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cooldown table assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define KCT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cooldown table assertion failed");

`endif

@@ src/kct_pkg.sv @@
// Types and constants of the keyed cooldown table.
package kct_pkg;

	localparam int unsigned KEY_W  = 32;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned SLOT_W = 3;

	localparam logic [TIME_W-1:0] COOLDOWN_RESET = 32'd60000;

	typedef enum logic [1:0] {
		ACT_SUPPRESSED = 2'd0,
		ACT_REFRESHED  = 2'd1,
		ACT_INSERTED   = 2'd2,
		ACT_REPLACED   = 2'd3
	} action_t;

endpackage

@@ src/kct_req_if.sv @@
// Request channel carrying one event word: key hash and current time.
interface kct_req_if;

	logic                         valid;
	logic                         ready;
	logic [kct_pkg::KEY_W-1:0]    key_hash;
	logic [kct_pkg::TIME_W-1:0]   now_ms;

	modport source (output valid, output key_hash, output now_ms, input ready);
	modport sink   (input valid, input key_hash, input now_ms, output ready);

endinterface

@@ src/kct_rsp_if.sv @@
// Response channel carrying one result word per event.
interface kct_rsp_if;

	logic                         valid;
	logic                         ready;
	logic                         suppressed;
	logic [1:0]                   action;
	logic [kct_pkg::SLOT_W-1:0]   slot;

	modport source (output valid, output suppressed, output action, output slot, input ready);
	modport sink   (input valid, input suppressed, input action, input slot, output ready);

endinterface

@@ src/keyed_cooldown_table_core.sv @@
// Per-key cooldown table with a sequential search and oldest-entry replacement.
//
// Each request word carries a key hash and the current millisecond time. The block
// reads the table one entry per cycle through a single read port, tracking the first
// matching key, the first empty slot and the oldest stored time; one shared
// subtract-and-compare unit finds the oldest time and then also forms the elapsed
// time and checks it against cooldown_ms. An event passes through these steps, in
// order, before the next one is accepted: accept the word, read the table entries,
// compare the last entry, form the elapsed time, check it against cooldown_ms and
// write the table, and load the response. The response sits in its own
// register, so a new request is taken while the previous response waits; if that
// response is still waiting when the next one is ready, the block holds in its last
// step until the response is taken. Entries come out of reset empty through
// per-entry valid bits; no clearing pass is needed. cooldown_ms may be written only
// while idle.
`include "keyed_cooldown_table_core_macros.svh"

module keyed_cooldown_table_core #(
	parameter int unsigned ENTRIES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [kct_pkg::TIME_W-1:0]    cfg_wdata,
	kct_req_if.sink                       req,
	kct_rsp_if.source                     rsp
);

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_ELAPSED,
		ST_CHECK,
		ST_DONE
	} state_t;

	state_t                         state_q;
	logic [kct_pkg::TIME_W-1:0]     cool_q;
	logic [kct_pkg::KEY_W-1:0]      key_q;
	logic [kct_pkg::TIME_W-1:0]     now_q;
	logic [IW-1:0]                  addr_q;

	logic [kct_pkg::KEY_W-1:0]      key_mem [ENTRIES];
	logic [kct_pkg::TIME_W-1:0]     time_mem [ENTRIES];
	logic [ENTRIES-1:0]             entry_vld_q;

	logic [kct_pkg::KEY_W-1:0]      key_rd_s1;
	logic [kct_pkg::TIME_W-1:0]     time_rd_s1;
	logic                           vld_rd_s1;
	logic [IW-1:0]                  idx_s1;
	logic                           rd_en_s1;
	logic [kct_pkg::KEY_W-1:0]      rd_key;
	logic [kct_pkg::TIME_W-1:0]     rd_time;

	logic                           match_found_q;
	logic [IW-1:0]                  match_idx_q;
	logic [kct_pkg::TIME_W-1:0]     match_time_q;
	logic                           empty_found_q;
	logic [IW-1:0]                  empty_idx_q;
	logic [IW-1:0]                  old_idx_q;
	logic [kct_pkg::TIME_W-1:0]     old_time_q;
	logic [kct_pkg::TIME_W-1:0]     elapsed_q;

	logic [kct_pkg::TIME_W-1:0]     op_a;
	logic [kct_pkg::TIME_W-1:0]     op_b;
	logic [kct_pkg::TIME_W:0]       diff;
	logic                           lt;

	logic                           wr_en;
	logic [IW-1:0]                  wr_idx;
	logic                           res_supp_q;
	kct_pkg::action_t               res_act_q;
	logic [IW-1:0]                  res_idx_q;

	logic                           rsp_valid_q;
	logic                           rsp_supp_q;
	kct_pkg::action_t               rsp_act_q;
	logic [kct_pkg::SLOT_W-1:0]     rsp_slot_q;
	logic [63:0]                    res_idx_wide;
	logic                           rsp_free;

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.suppressed = rsp_supp_q;
	assign rsp.action     = rsp_act_q;
	assign rsp.slot       = rsp_slot_q;

	assign rsp_free     = !rsp_valid_q || rsp.ready;
	assign res_idx_wide = 64'(res_idx_q);

	assign rd_key  = vld_rd_s1 ? key_rd_s1 : '0;
	assign rd_time = vld_rd_s1 ? time_rd_s1 : '0;

	always_comb begin
		case (state_q)
			ST_ELAPSED: begin
				op_a = now_q;
				op_b = match_time_q;
			end
			ST_CHECK: begin
				op_a = elapsed_q;
				op_b = cool_q;
			end
			default: begin
				op_a = rd_time;
				op_b = old_time_q;
			end
		endcase
		diff = {1'b0, op_a} - {1'b0, op_b};
		lt   = diff[kct_pkg::TIME_W];
	end

	always_comb begin
		wr_en  = 1'b0;
		wr_idx = old_idx_q;
		if (state_q == ST_CHECK) begin
			if (match_found_q) begin
				wr_en  = !lt;
				wr_idx = match_idx_q;
			end else if (empty_found_q) begin
				wr_en  = 1'b1;
				wr_idx = empty_idx_q;
			end else begin
				wr_en  = 1'b1;
				wr_idx = old_idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_idx]  <= key_q;
			time_mem[wr_idx] <= now_q;
		end
		key_rd_s1  <= key_mem[addr_q];
		time_rd_s1 <= time_mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			vld_rd_s1   <= 1'b0;
		end else begin
			if (wr_en) begin
				entry_vld_q[wr_idx] <= 1'b1;
			end
			vld_rd_s1 <= entry_vld_q[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cool_q <= kct_pkg::COOLDOWN_RESET;
		end else if (cfg_we) begin
			cool_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			addr_q        <= '0;
			rd_en_s1      <= 1'b0;
			idx_s1        <= '0;
			key_q         <= '0;
			now_q         <= '0;
			match_found_q <= 1'b0;
			match_idx_q   <= '0;
			match_time_q  <= '0;
			empty_found_q <= 1'b0;
			empty_idx_q   <= '0;
			old_idx_q     <= '0;
			old_time_q    <= '0;
			elapsed_q     <= '0;
			res_supp_q    <= 1'b0;
			res_act_q     <= kct_pkg::ACT_SUPPRESSED;
			res_idx_q     <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_supp_q    <= 1'b0;
			rsp_act_q     <= kct_pkg::ACT_SUPPRESSED;
			rsp_slot_q    <= '0;
		end else begin
			rd_en_s1 <= (state_q == ST_SCAN);
			idx_s1   <= addr_q;

			if ((state_q == ST_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (rd_en_s1) begin
				if (!match_found_q && (rd_key == key_q)) begin
					match_found_q <= 1'b1;
					match_idx_q   <= idx_s1;
					match_time_q  <= rd_time;
				end
				if (!empty_found_q && (rd_key == '0)) begin
					empty_found_q <= 1'b1;
					empty_idx_q   <= idx_s1;
				end
				if ((idx_s1 == '0) || lt) begin
					old_idx_q  <= idx_s1;
					old_time_q <= rd_time;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						key_q         <= req.key_hash;
						now_q         <= req.now_ms;
						addr_q        <= '0;
						match_found_q <= 1'b0;
						empty_found_q <= 1'b0;
						state_q       <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (addr_q == LAST_IDX) begin
						state_q <= ST_LAST;
					end else begin
						addr_q <= addr_q + IW'(1);
					end
				end
				ST_LAST: begin
					state_q <= ST_ELAPSED;
				end
				ST_ELAPSED: begin
					elapsed_q <= diff[kct_pkg::TIME_W-1:0];
					state_q   <= ST_CHECK;
				end
				ST_CHECK: begin
					res_supp_q <= match_found_q && lt;
					res_idx_q  <= wr_idx;
					if (match_found_q) begin
						if (lt) begin
							res_act_q <= kct_pkg::ACT_SUPPRESSED;
						end else begin
							res_act_q <= kct_pkg::ACT_REFRESHED;
						end
					end else if (empty_found_q) begin
						res_act_q <= kct_pkg::ACT_INSERTED;
					end else begin
						res_act_q <= kct_pkg::ACT_REPLACED;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp_supp_q <= res_supp_q;
						rsp_act_q  <= res_act_q;
						rsp_slot_q <= res_idx_wide[kct_pkg::SLOT_W-1:0];
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`KCT_ASSERT_NEXT(a_accept_starts_scan, req.valid && req.ready, state_q == ST_SCAN)
	`KCT_ASSERT_NEXT(a_done_loads_rsp, state_q == ST_DONE && rsp_free, rsp_valid_q)
	`KCT_ASSERT_NOW(a_supp_matches_action, rsp_valid_q,
		rsp_supp_q == (rsp_act_q == kct_pkg::ACT_SUPPRESSED))
	`KCT_ASSERT_NOW(a_no_write_unless_check, wr_en, state_q == ST_CHECK)
	`KCT_ASSERT_NOW(a_scan_in_range, state_q == ST_SCAN, addr_q <= LAST_IDX)

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the keyed cooldown table: a directed table, then random events.
module tb_top;

	localparam int ENTRIES = 8;
	localparam int POOL_SIZE = 12;
	localparam int N_DIRECTED = 22;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT = 5000;

	typedef logic [kct_pkg::KEY_W-1:0]  key_t;
	typedef logic [kct_pkg::TIME_W-1:0] ms_t;
	typedef logic [kct_pkg::SLOT_W-1:0] slot_t;

	typedef struct packed {
		logic              suppressed;
		kct_pkg::action_t  action;
		slot_t             slot;
	} verdict_t;

	typedef struct packed {
		key_t              key;
		ms_t               now;
		logic              typed;
		verdict_t          verdict;
	} directed_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	ms_t               cfg_wdata;

	kct_req_if event_ch();
	kct_rsp_if verdict_ch();

	keyed_cooldown_table_core #(.ENTRIES(ENTRIES)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (event_ch),
		.rsp       (verdict_ch)
	);

	key_t              table_key  [ENTRIES];
	ms_t               table_time [ENTRIES];
	ms_t               cooldown_model;
	key_t              key_pool [POOL_SIZE];
	ms_t               clock_ms;
	verdict_t          verdict_q [$];
	directed_row_t     directed_rows [N_DIRECTED];

	int send_idle_pct;
	int recv_idle_pct;
	int errors;
	int events_sent;
	int verdicts_seen;
	int cooldown_writes;
	int stall_cycles;

	always #1 clk = ~clk;

	function automatic verdict_t predict_verdict(input key_t key, input ms_t now);
		verdict_t          v;
		ms_t               elapsed;
		ms_t               oldest;
		int                pick;
		for (int i = 0; i < ENTRIES; i++) begin
			if (table_key[i] == key) begin
				elapsed = now - table_time[i];
				v.slot = slot_t'(i);
				if (elapsed < cooldown_model) begin
					v.suppressed = 1'b1;
					v.action = kct_pkg::ACT_SUPPRESSED;
				end else begin
					table_time[i] = now;
					v.suppressed = 1'b0;
					v.action = kct_pkg::ACT_REFRESHED;
				end
				return v;
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (table_key[i] == '0) begin
				table_key[i] = key;
				table_time[i] = now;
				v.suppressed = 1'b0;
				v.action = kct_pkg::ACT_INSERTED;
				v.slot = slot_t'(i);
				return v;
			end
		end
		pick = 0;
		oldest = table_time[0];
		for (int i = 1; i < ENTRIES; i++) begin
			if (table_time[i] < oldest) begin
				pick = i;
				oldest = table_time[i];
			end
		end
		table_key[pick] = key;
		table_time[pick] = now;
		v.suppressed = 1'b0;
		v.action = kct_pkg::ACT_REPLACED;
		v.slot = slot_t'(pick);
		return v;
	endfunction

	task automatic send_event(input key_t key, input ms_t now,
			input logic typed, input verdict_t typed_verdict);
		verdict_t predicted;
		event_ch.valid <= 1'b1;
		event_ch.key_hash <= key;
		event_ch.now_ms <= now;
		@(posedge clk);
		while (!event_ch.ready)
			@(posedge clk);
		predicted = predict_verdict(key, now);
		verdict_q.push_back(typed ? typed_verdict : predicted);
		events_sent++;
	endtask

	task automatic idle_sender();
		if ($urandom_range(0, 99) < send_idle_pct) begin
			event_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
	endtask

	task automatic drain_verdicts();
		event_ch.valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_cooldown(input ms_t value);
		drain_verdicts();
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cooldown_model = value;
		cooldown_writes++;
	endtask

	task automatic run_random_events(input int count);
		key_t              key;
		ms_t               now;
		int unsigned       span;
		int                kind;
		int                idx;
		for (int k = 0; k < POOL_SIZE; k++)
			key_pool[k] = $urandom;
		if (cooldown_model == '0)
			span = 64;
		else if (cooldown_model > 2000)
			span = 2000;
		else
			span = cooldown_model;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 99);
			idx = $urandom_range(0, ENTRIES - 1);
			if (kind < 50) begin
				clock_ms += $urandom_range(0, 2 * span);
				key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
				now = clock_ms;
			end else if (kind < 65) begin
				key = table_key[idx];
				now = table_time[idx] + cooldown_model - $urandom_range(0, 1);
			end else if (kind < 75) begin
				key = table_key[idx];
				now = table_time[idx] - 1;
			end else if (kind < 85) begin
				clock_ms += $urandom_range(0, 2 * span);
				key = '0;
				now = clock_ms;
			end else begin
				key = $urandom;
				now = $urandom;
			end
			if (n == count / 2)
				drain_verdicts();
			send_event(key, now, 1'b0, '0);
			idle_sender();
		end
	endtask

	always @(posedge clk)
		verdict_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && verdict_ch.valid && verdict_ch.ready) begin
			verdicts_seen++;
			if (verdict_q.size() == 0) begin
				$error("verdict word arrived with no event outstanding");
				errors++;
			end else begin
				want = verdict_q.pop_front();
				if (verdict_ch.suppressed !== want.suppressed) begin
					$error("suppressed: expected %0d, got %0d", want.suppressed,
						verdict_ch.suppressed);
					errors++;
				end
				if (verdict_ch.action !== want.action) begin
					$error("action: expected %0d, got %0d", want.action, verdict_ch.action);
					errors++;
				end
				if (verdict_ch.slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, verdict_ch.slot);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((event_ch.valid && event_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		event_ch.valid = 1'b0;
		event_ch.key_hash = '0;
		event_ch.now_ms = '0;
		verdict_ch.ready = 1'b0;
		send_idle_pct = 11;
		recv_idle_pct = 86;
		errors = 0;
		events_sent = 0;
		verdicts_seen = 0;
		cooldown_writes = 0;
		stall_cycles = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			table_key[i] = '0;
			table_time[i] = '0;
		end
		cooldown_model = kct_pkg::COOLDOWN_RESET;
		clock_ms = $urandom;

		directed_rows = '{
			'{32'h0000_000A, 32'd1000,      1'b1, '{1'b0, kct_pkg::ACT_INSERTED,   3'd0}},
			'{32'h0000_000A, 32'd1500,      1'b1, '{1'b1, kct_pkg::ACT_SUPPRESSED, 3'd0}},
			'{32'h0000_000A, 32'd61000,     1'b1, '{1'b0, kct_pkg::ACT_REFRESHED,  3'd0}},
			'{32'h0000_000A, 32'd120999,    1'b1, '{1'b1, kct_pkg::ACT_SUPPRESSED, 3'd0}},
			'{32'h0000_0000, 32'd100,       1'b1, '{1'b1, kct_pkg::ACT_SUPPRESSED, 3'd1}},
			'{32'h0000_0000, 32'd70000,     1'b1, '{1'b0, kct_pkg::ACT_REFRESHED,  3'd1}},
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, kct_pkg::ACT_INSERTED,   3'd1}},
			'{32'h0000_0001, 32'd5,         1'b1, '{1'b0, kct_pkg::ACT_INSERTED,   3'd2}},
			'{32'h8000_0000, 32'd5,         1'b1, '{1'b0, kct_pkg::ACT_INSERTED,   3'd3}},
			'{32'h5555_5555, 32'h8000_0000, 1'b1, '{1'b0, kct_pkg::ACT_INSERTED,   3'd4}},
			'{32'hAAAA_AAAA, 32'h7FFF_FFFF, 1'b1, '{1'b0, kct_pkg::ACT_INSERTED,   3'd5}},
			'{32'h1234_5678, 32'd3000,      1'b1, '{1'b0, kct_pkg::ACT_INSERTED,   3'd6}},
			'{32'hDEAD_BEEF, 32'd900000,    1'b1, '{1'b0, kct_pkg::ACT_INSERTED,   3'd7}},
			'{32'h0000_0000, 32'd7,         1'b1, '{1'b0, kct_pkg::ACT_REPLACED,   3'd2}},
			'{32'h0BAD_F00D, 32'd10,        1'b1, '{1'b0, kct_pkg::ACT_INSERTED,   3'd2}},
			'{32'h0000_0000, 32'd20,        1'b0, '0},
			'{32'hFFFF_FFFF, 32'h0000_EA5F, 1'b0, '0},
			'{32'hFFFF_FFFF, 32'h0000_EA60, 1'b0, '0},
			'{32'h0000_0001, 32'h0000_0100, 1'b0, '0},
			'{32'h8000_0000, 32'h0000_0200, 1'b0, '0},
			'{32'h1234_5678, 32'd62999,     1'b0, '0},
			'{32'h1234_5678, 32'd63000,     1'b0, '0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++) begin
			send_event(directed_rows[r].key, directed_rows[r].now, directed_rows[r].typed,
				directed_rows[r].verdict);
			idle_sender();
		end

		write_cooldown(32'd100);
		run_random_events(120);
		write_cooldown('0);
		run_random_events(60);

		send_idle_pct = 86;
		recv_idle_pct = 11;
		write_cooldown(32'hFFFF_FFFF);
		run_random_events(80);
		write_cooldown(32'd1);
		run_random_events(100);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_cooldown($urandom_range(50, 500));
		run_random_events(120);
		write_cooldown(kct_pkg::COOLDOWN_RESET);
		run_random_events(120);

		drain_verdicts();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (verdict_q.size() != 0) begin
			$error("%0d verdict words never arrived", verdict_q.size());
			errors++;
		end

		$display("Sent %0d events and checked %0d verdict words across %0d cooldown writes,",
			events_sent, verdicts_seen, cooldown_writes);
		$display("covering zero and full-scale cooldowns, wrapped time and oldest replacement.");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
